>>> hdl/abarq_pkg.sv
// abarq_pkg: shared types and constants of the alternating-bit sender
// no dependencies; used by the interfaces, abarq_step and the top level
`timescale 1ns / 1ps
`default_nettype none

package abarq_pkg;

    // default width of the chunk counter
    localparam int COUNT_BITS_DEFAULT = 32;

    // fixed field widths
    localparam int ACTION_BITS   = 3;
    localparam int ACK_BITS      = 2;
    localparam int KIND_BITS     = 2;
    localparam int STATUS_BITS   = 2;
    localparam int RETRY_CFG_BITS = 8;
    localparam int RETRY_BITS    = 9;
    localparam int CHUNK_NUM_BITS = 32;

    localparam logic [RETRY_CFG_BITS-1:0] RETRY_LIMIT_RESET = 8'd15;
    localparam logic [RETRY_BITS-1:0]     RETRY_SAT         = 9'd511;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_START = 3'd0,
        ACT_CHUNK = 3'd1,
        ACT_END   = 3'd2,
        ACT_TMO   = 3'd3,
        ACT_ACK   = 3'd4
    } action_t;

    typedef enum logic [ACK_BITS-1:0] {
        ACK_ZERO = 2'd0,
        ACK_ONE  = 2'd1,
        ACK_UNKN = 2'd2
    } ack_t;

    typedef enum logic [KIND_BITS-1:0] {
        SEND_NONE   = 2'd0,
        SEND_NEW    = 2'd1,
        SEND_RESEND = 2'd2,
        SEND_FINISH = 2'd3
    } send_kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        PH_WAIT_DATA = 2'd0,
        PH_WAIT_ACK  = 2'd1,
        PH_DONE      = 2'd2,
        PH_ERROR     = 2'd3
    } phase_t;

    // protocol control state apart from the chunk counter
    typedef struct packed {
        phase_t                phase;
        logic                  seq;
        logic [RETRY_BITS-1:0] retry;
    } ctl_t;

    // per-item decision that goes to the result register
    typedef struct packed {
        send_kind_t kind;
        logic       accepted;
    } decision_t;

endpackage

`default_nettype wire

>>> hdl/abarq_ifs.sv
// abarq_ifs: valid/ready channels of the sender (events, results, config)
// depends on abarq_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface abarq_event_if;
    logic                               valid;
    logic                               ready;
    logic [abarq_pkg::ACTION_BITS-1:0]  action;
    logic [abarq_pkg::ACK_BITS-1:0]     ack_type;
    logic                               link_ok;

    modport source (output valid, action, ack_type, link_ok, input ready);
    modport sink   (input valid, action, ack_type, link_ok, output ready);
endinterface

interface abarq_result_if;
    logic                                  valid;
    logic                                  ready;
    logic [abarq_pkg::KIND_BITS-1:0]       send_kind;
    logic                                  seq_bit;
    logic [abarq_pkg::CHUNK_NUM_BITS-1:0]  chunk_number;
    logic [abarq_pkg::STATUS_BITS-1:0]     status;
    logic                                  accepted;

    modport source (output valid, send_kind, seq_bit, chunk_number, status, accepted,
                    input ready);
    modport sink   (input valid, send_kind, seq_bit, chunk_number, status, accepted,
                    output ready);
endinterface

interface abarq_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [abarq_pkg::RETRY_CFG_BITS-1:0]  retry_limit;

    modport source (output valid, retry_limit, input ready);
    modport sink   (input valid, retry_limit, output ready);
endinterface

`default_nettype wire

>>> hdl/alternating_bit_arq_sender.sv
// alternating_bit_arq_sender: top level of the stop-and-wait sender
// depends on abarq_pkg, abarq_ifs and abarq_step
`timescale 1ns / 1ps
`default_nettype none

// Stop-and-wait (alternating-bit) ARQ sender. Each event item on evt
// (start, chunk ready, end of data, timeout, ack) yields exactly one result
// item on res telling the link what to send, with the sequence bit, chunk
// count and phase after the event. An event is decided in the cycle it is
// accepted and its result sits in the output register from the next cycle,
// so one event per clock is taken, and evt.ready only drops while a result
// waits in the output register and res.ready is low.
// The single register retry_limit (reset 15) is written through cfg, which
// is always ready; write it only while no result is outstanding.
module alternating_bit_arq_sender #(
    parameter int COUNT_BITS = abarq_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    abarq_event_if.sink  evt,
    abarq_result_if.source res,
    abarq_cfg_if.sink    cfg
);

    // protocol state
    abarq_pkg::ctl_t                      ctl_reg;
    abarq_pkg::ctl_t                      ctl_next;
    logic [COUNT_BITS-1:0]                chunks_reg;
    logic [COUNT_BITS-1:0]                chunks_next;
    logic [abarq_pkg::RETRY_CFG_BITS-1:0] retry_limit_reg;

    // result register
    logic                                 out_valid_reg;
    abarq_pkg::decision_t                 dec;
    abarq_pkg::decision_t                 dec_reg;
    logic                                 seq_out_reg;
    logic [abarq_pkg::CHUNK_NUM_BITS-1:0] chunk_out_reg;
    abarq_pkg::phase_t                    status_reg;

    logic                                 evt_fire;

    // take a new event whenever the output register is free or draining
    assign evt.ready = !out_valid_reg || res.ready;
    assign evt_fire  = evt.valid && evt.ready;
    assign cfg.ready = 1'b1;

    abarq_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .action      (evt.action),
        .ack_type    (evt.ack_type),
        .link_ok     (evt.link_ok),
        .retry_limit (retry_limit_reg),
        .ctl         (ctl_reg),
        .chunks      (chunks_reg),
        .ctl_next    (ctl_next),
        .chunks_next (chunks_next),
        .dec         (dec)
    );

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            retry_limit_reg <= abarq_pkg::RETRY_LIMIT_RESET;
        else if (cfg.valid)
            retry_limit_reg <= cfg.retry_limit;
    end

    // protocol state advances once per accepted event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.phase <= abarq_pkg::PH_WAIT_DATA;
            ctl_reg.seq   <= 1'b0;
            ctl_reg.retry <= '0;
            chunks_reg    <= '0;
        end
        else if (evt_fire)
        begin
            ctl_reg    <= ctl_next;
            chunks_reg <= chunks_next;
        end
    end

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (evt_fire)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            dec_reg       <= dec;
            seq_out_reg   <= ctl_next.seq;
            // report the low word of the counter, zero-extended if narrower
            chunk_out_reg <= abarq_pkg::CHUNK_NUM_BITS'(chunks_next);
            status_reg    <= ctl_next.phase;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.send_kind    = dec_reg.kind;
    assign res.seq_bit      = seq_out_reg;
    assign res.chunk_number = chunk_out_reg;
    assign res.status       = status_reg;
    assign res.accepted     = dec_reg.accepted;

`ifndef SYNTH
    // every accepted event produces a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        evt_fire |=> res.valid)
        else $error("no result after accepted event");

    // a start event always reports a cleared transfer
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_fire && evt.action == abarq_pkg::ACT_START)
        |=> (res.status == abarq_pkg::PH_WAIT_DATA && res.chunk_number == '0
             && !res.seq_bit && res.accepted))
        else $error("start did not clear state");

    // a new chunk leaves the sender waiting for its ack
    a_new_waits_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.send_kind == abarq_pkg::SEND_NEW)
        |-> res.status == abarq_pkg::PH_WAIT_ACK)
        else $error("new chunk sent without waiting for ack");

    // finished or failed transfers only leave on start
    a_terminal_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_fire && evt.action != abarq_pkg::ACT_START
         && (ctl_reg.phase == abarq_pkg::PH_DONE || ctl_reg.phase == abarq_pkg::PH_ERROR))
        |=> (ctl_reg == $past(ctl_reg) && !res.accepted))
        else $error("terminal phase left without start");
`endif

endmodule

`default_nettype wire

>>> hdl/abarq_step.sv
// abarq_step: next-state and send decision for one event
// depends on abarq_pkg
`timescale 1ns / 1ps
`default_nettype none

module abarq_step #(
    parameter int COUNT_BITS = abarq_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic [abarq_pkg::ACTION_BITS-1:0]    action,
    input  wire logic [abarq_pkg::ACK_BITS-1:0]       ack_type,
    input  wire logic                                 link_ok,
    input  wire logic [abarq_pkg::RETRY_CFG_BITS-1:0] retry_limit,
    input  wire abarq_pkg::ctl_t                      ctl,
    input  wire logic [COUNT_BITS-1:0]                chunks,
    output abarq_pkg::ctl_t                           ctl_next,
    output logic      [COUNT_BITS-1:0]                chunks_next,
    output abarq_pkg::decision_t                      dec
);

    logic [abarq_pkg::RETRY_BITS-1:0] retry_inc;
    logic                             ack_match;

    // saturating retry increment
    assign retry_inc = (ctl.retry == abarq_pkg::RETRY_SAT) ? ctl.retry
                     : ctl.retry + abarq_pkg::RETRY_BITS'(1);
    assign ack_match = (ack_type == abarq_pkg::ACK_ZERO && !ctl.seq)
                    || (ack_type == abarq_pkg::ACK_ONE && ctl.seq);

    always_comb
    begin
        ctl_next     = ctl;
        chunks_next  = chunks;
        dec.kind     = abarq_pkg::SEND_NONE;
        dec.accepted = 1'b0;
        unique case (action)
            abarq_pkg::ACT_START:
            begin
                ctl_next.phase = abarq_pkg::PH_WAIT_DATA;
                ctl_next.seq   = 1'b0;
                ctl_next.retry = '0;
                chunks_next    = '0;
                dec.accepted   = 1'b1;
            end
            abarq_pkg::ACT_CHUNK:
            begin
                if (ctl.phase == abarq_pkg::PH_WAIT_DATA)
                begin
                    dec.accepted   = 1'b1;
                    ctl_next.retry = '0;
                    if (link_ok)
                    begin
                        dec.kind       = abarq_pkg::SEND_NEW;
                        chunks_next    = chunks + COUNT_BITS'(1);
                        ctl_next.phase = abarq_pkg::PH_WAIT_ACK;
                    end
                    else
                    begin
                        ctl_next.phase = abarq_pkg::PH_ERROR;
                    end
                end
            end
            abarq_pkg::ACT_END:
            begin
                if (ctl.phase == abarq_pkg::PH_WAIT_DATA)
                begin
                    dec.accepted   = 1'b1;
                    dec.kind       = abarq_pkg::SEND_FINISH;
                    ctl_next.phase = abarq_pkg::PH_DONE;
                end
            end
            abarq_pkg::ACT_TMO:
            begin
                if (ctl.phase == abarq_pkg::PH_WAIT_ACK)
                begin
                    dec.accepted = 1'b1;
                    if (link_ok)
                    begin
                        dec.kind       = abarq_pkg::SEND_RESEND;
                        ctl_next.retry = retry_inc;
                        if (retry_inc > {1'b0, retry_limit})
                            ctl_next.phase = abarq_pkg::PH_ERROR;
                    end
                    else
                    begin
                        ctl_next.phase = abarq_pkg::PH_ERROR;
                    end
                end
            end
            abarq_pkg::ACT_ACK:
            begin
                if (ctl.phase == abarq_pkg::PH_WAIT_ACK)
                begin
                    dec.accepted = 1'b1;
                    // stale and unknown acks change nothing
                    if (ack_match)
                    begin
                        ctl_next.seq   = ~ctl.seq;
                        ctl_next.phase = abarq_pkg::PH_WAIT_DATA;
                    end
                end
            end
            default:
            begin
                // unused event codes: ignored
            end
        endcase
    end

endmodule

`default_nettype wire

>>> verif/tb_alternating_bit_arq_sender.sv
// tb_alternating_bit_arq_sender: self-checking testbench of the stop-and-wait sender
// depends on abarq_pkg, abarq_ifs and alternating_bit_arq_sender from hdl
// directed and random event items against a cycle-free predictor, random stalls
`timescale 1ns / 1ps

module tb_alternating_bit_arq_sender;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 5;
    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 180;
    localparam int LONG_HOLD        = 64;     // receiver hold-off, cycles
    localparam int SETTLE_CYCLES    = 4;      // spare cycles after the last result
    localparam int QUIET_LIMIT      = 1000;   // cycles with no handshake at all

    // codes that the event fields allow but the protocol leaves unused
    localparam logic [abarq_pkg::ACTION_BITS-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [abarq_pkg::ACTION_BITS-1:0] ACT_SPARE_HI = 3'd7;
    localparam logic [abarq_pkg::ACK_BITS-1:0]    ACK_SPARE    = 2'd3;

    // one event item waiting to be offered
    typedef struct {
        logic [abarq_pkg::ACTION_BITS-1:0] action;
        logic [abarq_pkg::ACK_BITS-1:0]    ack_type;
        logic                              link_ok;
    } sender_event_t;

    // one expected result item
    typedef struct {
        abarq_pkg::send_kind_t                kind;
        logic                                 seq;
        logic [abarq_pkg::CHUNK_NUM_BITS-1:0] chunk;
        abarq_pkg::phase_t                    status;
        logic                                 accepted;
    } link_order_t;

    logic clk;
    logic rst_n;

    abarq_event_if  evt();
    abarq_result_if res();
    abarq_cfg_if    cfg();

    alternating_bit_arq_sender dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .res   (res),
        .cfg   (cfg)
    );

    // stimulus backlog and the link orders still owed by the block
    sender_event_t event_backlog[$];
    link_order_t   due_orders[$];
    int            queued_total;
    int            mismatches;

    // idling controls, set per phase by the sequencer
    int gap_max;
    int stall_max;
    int hold_asks;
    int hold_done;

    // handshake flags of the last rising edge
    logic evt_took;
    logic res_took;
    logic cfg_took;

    // predictor state, mirrors the sender after every accepted item
    abarq_pkg::phase_t                        m_phase;
    logic                                     m_seq;
    logic [abarq_pkg::RETRY_BITS-1:0]         m_retry;
    logic [abarq_pkg::COUNT_BITS_DEFAULT-1:0] m_chunks;
    logic [abarq_pkg::RETRY_CFG_BITS-1:0]     m_retry_limit;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor: apply one event to the mirrored sender state
    // ------------------------------------------------------------------
    function automatic link_order_t advance_sender(
        input logic [abarq_pkg::ACTION_BITS-1:0] act,
        input logic [abarq_pkg::ACK_BITS-1:0]    ack,
        input logic                              link);
        link_order_t o;
        o.kind     = abarq_pkg::SEND_NONE;
        o.accepted = 1'b0;
        case (act)
            abarq_pkg::ACT_START:
            begin
                // start applies in every phase and clears everything
                m_phase  = abarq_pkg::PH_WAIT_DATA;
                m_seq    = 1'b0;
                m_retry  = '0;
                m_chunks = '0;
                o.accepted = 1'b1;
            end
            abarq_pkg::ACT_CHUNK:
            begin
                if (m_phase == abarq_pkg::PH_WAIT_DATA)
                begin
                    o.accepted = 1'b1;
                    m_retry = '0;
                    if (link)
                    begin
                        o.kind   = abarq_pkg::SEND_NEW;
                        m_chunks = m_chunks + abarq_pkg::COUNT_BITS_DEFAULT'(1);
                        m_phase  = abarq_pkg::PH_WAIT_ACK;
                    end
                    else
                    begin
                        // link refused the new chunk
                        m_phase = abarq_pkg::PH_ERROR;
                    end
                end
            end
            abarq_pkg::ACT_END:
            begin
                // finish goes out whatever the link says
                if (m_phase == abarq_pkg::PH_WAIT_DATA)
                begin
                    o.accepted = 1'b1;
                    o.kind     = abarq_pkg::SEND_FINISH;
                    m_phase    = abarq_pkg::PH_DONE;
                end
            end
            abarq_pkg::ACT_TMO:
            begin
                if (m_phase == abarq_pkg::PH_WAIT_ACK)
                begin
                    o.accepted = 1'b1;
                    if (link)
                    begin
                        // resend is reported even when it breaks the retry limit
                        o.kind = abarq_pkg::SEND_RESEND;
                        if (m_retry != abarq_pkg::RETRY_SAT)
                            m_retry = m_retry + abarq_pkg::RETRY_BITS'(1);
                        if (m_retry > {1'b0, m_retry_limit})
                            m_phase = abarq_pkg::PH_ERROR;
                    end
                    else
                    begin
                        m_phase = abarq_pkg::PH_ERROR;
                    end
                end
            end
            abarq_pkg::ACT_ACK:
            begin
                // stale and unknown acks are taken but change nothing
                if (m_phase == abarq_pkg::PH_WAIT_ACK)
                begin
                    o.accepted = 1'b1;
                    if ((ack == abarq_pkg::ACK_ZERO && !m_seq)
                        || (ack == abarq_pkg::ACK_ONE && m_seq))
                    begin
                        m_seq   = ~m_seq;
                        m_phase = abarq_pkg::PH_WAIT_DATA;
                    end
                end
            end
            default:
            begin
                // unused action codes are refused
            end
        endcase
        o.seq    = m_seq;
        o.chunk  = m_chunks[abarq_pkg::CHUNK_NUM_BITS-1:0];
        o.status = m_phase;
        return o;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor: sample handshakes at the rising edge, predict and compare
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        link_order_t want;
        if (!rst_n)
        begin
            evt_took      <= 1'b0;
            res_took      <= 1'b0;
            cfg_took      <= 1'b0;
            m_phase       = abarq_pkg::PH_WAIT_DATA;
            m_seq         = 1'b0;
            m_retry       = '0;
            m_chunks      = '0;
            m_retry_limit = abarq_pkg::RETRY_LIMIT_RESET;
        end
        else
        begin
            evt_took <= evt.valid && evt.ready;
            res_took <= res.valid && res.ready;
            cfg_took <= cfg.valid && cfg.ready;

            // register writes only happen while idle
            if (cfg.valid && cfg.ready)
                m_retry_limit = cfg.retry_limit;

            // compare before predicting so a result in the same cycle as its event cannot hide
            if (res.valid && res.ready)
            begin
                if (due_orders.size() == 0)
                begin
                    $display("%0t: result item with none expected, kind %0d status %0d",
                             $time, res.send_kind, res.status);
                    mismatches++;
                end
                else
                begin
                    want = due_orders.pop_front();
                    check_field("send_kind", want.kind, res.send_kind);
                    check_field("seq_bit", want.seq, res.seq_bit);
                    check_field("chunk_number", want.chunk, res.chunk_number);
                    check_field("status", want.status, res.status);
                    check_field("accepted", want.accepted, res.accepted);
                end
            end

            if (evt.valid && evt.ready)
                due_orders.push_back(advance_sender(evt.action, evt.ack_type, evt.link_ok));
        end
    end

    // ------------------------------------------------------------------
    // event driver: offers backlog items at the falling edge
    // ------------------------------------------------------------------
    int            gap_left;
    sender_event_t next_evt;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            evt.valid <= 1'b0;
            gap_left  <= 0;
        end
        else if (evt.valid && !evt_took)
        begin
            // item still on offer, keep it steady
        end
        else if (gap_left != 0)
        begin
            evt.valid <= 1'b0;
            gap_left  <= gap_left - 1;
        end
        else if (event_backlog.size() != 0)
        begin
            next_evt = event_backlog.pop_front();
            evt.action   <= next_evt.action;
            evt.ack_type <= next_evt.ack_type;
            evt.link_ok  <= next_evt.link_ok;
            evt.valid    <= 1'b1;
            gap_left     <= $urandom_range(0, gap_max);
        end
        else
        begin
            evt.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result receiver: per-item stalls plus an occasional long hold-off
    // ------------------------------------------------------------------
    int rx_wait;
    int hold_left;

    always @(negedge clk)
    begin
        int w;
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            rx_wait   <= 0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            res.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_done)
        begin
            // long hold-off so the output register fills and evt stalls
            hold_done <= hold_done + 1;
            hold_left <= LONG_HOLD - 1;
            res.ready <= 1'b0;
        end
        else if (res_took)
        begin
            w = $urandom_range(0, stall_max);
            res.ready <= (w == 0);
            rx_wait   <= (w == 0) ? 0 : w - 1;
        end
        else if (rx_wait != 0)
        begin
            res.ready <= 1'b0;
            rx_wait   <= rx_wait - 1;
        end
        else
        begin
            res.ready <= 1'b1;
        end
    end

    // watchdog: ends the run when nothing moves for too long
    int quiet_cycles;

    always @(posedge clk)
    begin
        if ((evt.valid && evt.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic queue_event(input logic [abarq_pkg::ACTION_BITS-1:0] a,
                               input logic [abarq_pkg::ACK_BITS-1:0] k,
                               input logic l);
        sender_event_t e;
        e.action   = a;
        e.ack_type = k;
        e.link_ok  = l;
        event_backlog.push_back(e);
        queued_total++;
    endtask

    // random ack field and link flag
    function automatic logic [abarq_pkg::ACK_BITS-1:0] rand_ack();
        return abarq_pkg::ACK_BITS'($urandom_range(0, 3));
    endfunction

    function automatic logic rand_link();
        return 1'($urandom_range(0, 1));
    endfunction

    // corner items with the reset retry limit
    task automatic add_directed();
        queue_event(abarq_pkg::ACT_ACK, abarq_pkg::ACK_ONE, 1'b1);    // ack while waiting for data
        queue_event(abarq_pkg::ACT_TMO, abarq_pkg::ACK_ZERO, 1'b1);   // timeout while waiting
        queue_event(ACT_SPARE_LO, ACK_SPARE, 1'b0);                   // unused action codes
        queue_event(ACT_SPARE_HI, abarq_pkg::ACK_UNKN, 1'b1);
        queue_event(abarq_pkg::ACT_CHUNK, ACK_SPARE, 1'b1);           // first chunk, seq 0
        queue_event(abarq_pkg::ACT_CHUNK, abarq_pkg::ACK_ZERO, 1'b1); // chunk while waiting ack
        queue_event(abarq_pkg::ACT_END, abarq_pkg::ACK_ZERO, 1'b1);   // end while waiting ack
        queue_event(abarq_pkg::ACT_ACK, abarq_pkg::ACK_ONE, 1'b0);    // stale ack
        queue_event(abarq_pkg::ACT_ACK, abarq_pkg::ACK_UNKN, 1'b1);   // unknown ack types
        queue_event(abarq_pkg::ACT_ACK, ACK_SPARE, 1'b1);
        queue_event(abarq_pkg::ACT_TMO, abarq_pkg::ACK_ZERO, 1'b1);   // resend
        queue_event(abarq_pkg::ACT_TMO, abarq_pkg::ACK_ZERO, 1'b0);   // refused resend
        queue_event(abarq_pkg::ACT_CHUNK, abarq_pkg::ACK_ZERO, 1'b1); // ignored in error
        queue_event(abarq_pkg::ACT_START, ACK_SPARE, 1'b0);
        queue_event(abarq_pkg::ACT_CHUNK, abarq_pkg::ACK_ZERO, 1'b0); // refused new chunk
        queue_event(abarq_pkg::ACT_START, abarq_pkg::ACK_ZERO, 1'b1);
        queue_event(abarq_pkg::ACT_CHUNK, abarq_pkg::ACK_ZERO, 1'b1);
        queue_event(abarq_pkg::ACT_ACK, abarq_pkg::ACK_ZERO, 1'b1);   // matching ack flips bit
        queue_event(abarq_pkg::ACT_CHUNK, abarq_pkg::ACK_ONE, 1'b1);  // chunk with seq 1
        queue_event(abarq_pkg::ACT_ACK, abarq_pkg::ACK_ONE, 1'b0);
        queue_event(abarq_pkg::ACT_END, abarq_pkg::ACK_UNKN, 1'b0);   // finish, refusing link
        queue_event(abarq_pkg::ACT_END, abarq_pkg::ACK_ZERO, 1'b1);   // ignored once complete
        queue_event(abarq_pkg::ACT_ACK, abarq_pkg::ACK_ONE, 1'b1);
        queue_event(abarq_pkg::ACT_START, abarq_pkg::ACK_ZERO, 1'b0); // start from complete
    endtask

    // one chunk then timeouts right up to and past the retry limit
    task automatic add_retry_burst(input int limit);
        queue_event(abarq_pkg::ACT_START, abarq_pkg::ACK_ZERO, 1'b1);
        queue_event(abarq_pkg::ACT_CHUNK, abarq_pkg::ACK_ZERO, 1'b1);
        for (int i = 0; i <= limit; i++)
            queue_event(abarq_pkg::ACT_TMO, rand_ack(), 1'b1);
        queue_event(abarq_pkg::ACT_ACK, abarq_pkg::ACK_ZERO, 1'b1);   // too late, in error
        queue_event(abarq_pkg::ACT_START, abarq_pkg::ACK_ZERO, 1'b1);
    endtask

    // a well-formed transfer with random content and the odd fault
    task automatic add_transfer();
        logic seq;
        int   chunks;
        int   tmos;
        seq    = 1'b0;
        chunks = $urandom_range(1, 6);
        queue_event(abarq_pkg::ACT_START, rand_ack(), rand_link());
        for (int c = 0; c < chunks; c++)
        begin
            queue_event(abarq_pkg::ACT_CHUNK, rand_ack(), $urandom_range(0, 15) != 0);
            tmos = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
            for (int t = 0; t < tmos; t++)
                queue_event(abarq_pkg::ACT_TMO, rand_ack(), $urandom_range(0, 31) != 0);
            case ($urandom_range(0, 7))
                0: queue_event(abarq_pkg::ACT_ACK,
                               seq ? abarq_pkg::ACK_ZERO : abarq_pkg::ACK_ONE, rand_link());
                1: queue_event(abarq_pkg::ACT_ACK,
                               rand_link() ? abarq_pkg::ACK_UNKN : ACK_SPARE, rand_link());
                default: ;
            endcase
            queue_event(abarq_pkg::ACT_ACK,
                        seq ? abarq_pkg::ACK_ONE : abarq_pkg::ACK_ZERO, rand_link());
            seq = ~seq;
        end
        queue_event(abarq_pkg::ACT_END, rand_ack(), rand_link());
    endtask

    task automatic add_random_items(input int count);
        int target;
        target = queued_total + count;
        while (queued_total < target)
        begin
            if ($urandom_range(0, 7) != 0)
                add_transfer();
            else
                repeat ($urandom_range(1, 4))
                    queue_event(abarq_pkg::ACTION_BITS'($urandom_range(0, 7)), rand_ack(),
                                rand_link());
        end
    endtask

    // wait until every item is taken and every result has come, then settle
    task automatic settle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (event_backlog.size() != 0 || due_orders.size() != 0 || (evt.valid && !evt_took));
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_retry_limit(input logic [abarq_pkg::RETRY_CFG_BITS-1:0] value);
        @(negedge clk);
        cfg.retry_limit <= value;
        cfg.valid       <= 1'b1;
        do
        begin
            @(posedge clk);
            #1;
        end
        while (!cfg_took);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequencer: reset, then phases of retry limit, idling and stimulus
    // ------------------------------------------------------------------
    int limit_plan[PHASES];
    int gap_plan[PHASES];
    int stall_plan[PHASES];

    initial
    begin
        // first phase runs on the reset limit; extremes, small values and a random value follow
        limit_plan = '{int'(abarq_pkg::RETRY_LIMIT_RESET), 0, 255, 1,
                       $urandom_range(2, 254), 3};
        gap_plan   = '{8, 0, 0, 8, 3, 8};
        stall_plan = '{8, 0, 8, 0, 8, 3};

        rst_n           = 1'b0;
        evt.valid       = 1'b0;
        evt.action      = abarq_pkg::ACT_START;
        evt.ack_type    = abarq_pkg::ACK_ZERO;
        evt.link_ok     = 1'b0;
        res.ready       = 1'b0;
        cfg.valid       = 1'b0;
        cfg.retry_limit = abarq_pkg::RETRY_LIMIT_RESET;
        queued_total    = 0;
        mismatches      = 0;
        hold_asks       = 0;
        hold_done       = 0;
        quiet_cycles    = 0;
        gap_max         = 0;
        stall_max       = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            // the sequencer waits here until every result of the last phase is in
            if (p != 0)
            begin
                settle();
                write_retry_limit(abarq_pkg::RETRY_CFG_BITS'(limit_plan[p]));
            end
            gap_max   = gap_plan[p];
            stall_max = stall_plan[p];
            if (p == 0)
                add_directed();
            add_retry_burst(limit_plan[p]);
            add_random_items(RANDOM_PER_PHASE);
            // back-to-back offers while the receiver holds off
            if (p == 2)
                hold_asks++;
        end

        settle();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
